// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, gated by i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== src/fpr_pkg.sv =====
// ---------------------------------------------------------------------------
// fpr_pkg
// Types and constants shared by the FIFO page replacement block.
// ---------------------------------------------------------------------------
package fpr_pkg;

    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 20;

    localparam int CFG_W   = 4;
    localparam int PAGE_W  = 20;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;
    localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              ev_valid;
        logic [PAGE_W-1:0] ev_page;
        logic [CNT_W-1:0]  faults;
        logic [CNT_W-1:0]  hits;
        logic              final_ref;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ===== src/fpr_ram.sv =====
// ---------------------------------------------------------------------------
// fpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fpr_ctrl.sv =====
// ---------------------------------------------------------------------------
// fpr_ctrl
// Frame scan sequencer: walks the page RAM, then commits the hit or fault.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fpr_ctrl
    import fpr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    localparam int AW        = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CFG_W-1:0]     i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_final,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    t_state               r_state, n_state;
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_final;
    logic [AW-1:0]        r_last;
    logic [AW-1:0]        r_victim;
    logic                 r_rd_more;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_cmp_vld;
    logic [AW-1:0]        r_cmp_idx;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic                 r_empty;
    logic [AW-1:0]        r_empty_idx;
    logic [PAGE_BITS-1:0] r_evict_page;
    logic                 r_valid [NUM_FRAMES];
    logic [AW-1:0]        r_ptr;
    logic [CNT_W-1:0]     r_faults;
    logic [CNT_W-1:0]     r_hits;

    logic [AW-1:0]        last_c;
    logic [AW-1:0]        victim_c;
    logic                 in_fire;
    logic                 done_fire;
    logic                 rd_en;
    logic [PAGE_BITS-1:0] rd_data;
    logic                 match;
    logic [AW-1:0]        slot;
    logic [AW+2:0]        slot_ext;
    logic                 ev_valid;
    logic [CNT_W-1:0]     n_faults;
    logic [CNT_W-1:0]     n_hits;

    // Clamp the frame count to 1..NUM_FRAMES and keep it as a last index.
    always_comb begin
        if (i_cfg == '0) begin
            last_c = '0;
        end else if (int'(i_cfg) > NUM_FRAMES) begin
            last_c = AW'(NUM_FRAMES - 1);
        end else begin
            last_c = AW'(i_cfg - CFG_W'(1));
        end
        victim_c = (r_ptr <= last_c) ? r_ptr : '0;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign done_fire  = (r_state == S_DONE) && i_res_ready;
    assign rd_en      = (r_state == S_SCAN) && r_rd_more;

    fpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (NUM_FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (done_fire && !r_hit),
        .i_waddr (slot),
        .i_wdata (r_page),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    assign match = r_cmp_vld && r_valid[r_cmp_idx] && (rd_data == r_page);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cmp_vld && (r_cmp_idx == r_last)) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commit values for the item that finished scanning.
    always_comb begin
        slot     = r_hit ? r_hit_idx : (r_empty ? r_empty_idx : r_victim);
        ev_valid = !r_hit && !r_empty;
        n_faults = (!r_hit && (r_faults != CNT_MAX)) ? r_faults + 1'b1 : r_faults;
        n_hits   = (r_hit && (r_hits != CNT_MAX)) ? r_hits + 1'b1 : r_hits;
        slot_ext = (AW+3)'(slot);
    end

    always_comb begin
        o_res_valid     = (r_state == S_DONE);
        o_res.hit       = r_hit;
        o_res.slot      = slot_ext[SLOT_W-1:0];
        o_res.ev_valid  = ev_valid;
        o_res.ev_page   = ev_valid ? PAGE_W'(r_evict_page) : '0;
        o_res.faults    = n_faults;
        o_res.hits      = n_hits;
        o_res.final_ref = r_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_more <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_ptr     <= '0;
            r_faults  <= '0;
            r_hits    <= '0;
            for (int k = 0; k < NUM_FRAMES; k++) r_valid[k] <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            if (in_fire) begin
                r_rd_more <= 1'b1;
                r_cmp_vld <= 1'b0;
            end else if (rd_en && (r_rd_idx == r_last)) begin
                r_rd_more <= 1'b0;
            end
            if (done_fire) begin
                if (r_final) begin
                    // End of string: drop every frame, rewind, zero the totals.
                    for (int k = 0; k < NUM_FRAMES; k++) r_valid[k] <= 1'b0;
                    r_ptr    <= '0;
                    r_faults <= '0;
                    r_hits   <= '0;
                end else begin
                    if (!r_hit) r_valid[slot] <= 1'b1;
                    if (ev_valid) r_ptr <= (slot == r_last) ? '0 : AW'(slot + 1'b1);
                    r_faults <= n_faults;
                    r_hits   <= n_hits;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_page   <= i_page;
            r_final  <= i_final;
            r_last   <= last_c;
            r_victim <= victim_c;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
            r_empty  <= 1'b0;
        end else begin
            if (rd_en) r_rd_idx <= AW'(r_rd_idx + 1'b1);
            if (r_cmp_vld) begin
                if (match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!r_valid[r_cmp_idx] && !r_empty) begin
                    r_empty     <= 1'b1;
                    r_empty_idx <= r_cmp_idx;
                end
                if (r_cmp_idx == r_victim) r_evict_page <= rd_data;
            end
        end
        if (rd_en) r_cmp_idx <= r_rd_idx;
    end

    `ASSERT_CLK(a_ptr_range, int'(r_ptr) < NUM_FRAMES, "replace pointer out of range")
    `ASSERT_IMPL(a_cmp_range, r_cmp_vld, r_cmp_idx <= r_last, "compare index past frame count")
    `ASSERT_CLK(a_done_idle, done_fire |=> (r_state == S_IDLE), "commit did not return to idle")

endmodule

// ===== src/fifo_page_replacement.sv =====
// ---------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement unit: one page reference in, one hit/fault result out.
// ---------------------------------------------------------------------------
// s_axis carries one page reference per beat (tdata: page number, tlast: end
// of string). m_axis returns one result beat per reference: tuser is the hit
// flag, tdata the slot, eviction and running totals, tlast echoes end of string.
// i_cfg_we/i_cfg_wdata set the frames in use; write only while idle. A value
// of 0 acts as 1, values above NUM_FRAMES act as NUM_FRAMES.
// Timing: each reference walks the page RAM one frame per cycle through the
// single RAM read port; a new reference is taken only once the previous
// result has been committed and the block is idle again.
// Reset: i_rst_n (synchronous, active low) empties every frame, rewinds the
// replace pointer, zeroes the totals and sets the frame count to 3.
// Stall: a finished result waits in the output register; the next reference
// is still taken and scanned, and its commit holds until that register frees.
// ---------------------------------------------------------------------------
module fifo_page_replacement
    import fpr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: frames_in_use
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // reference stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [19:0] page_number, [23:20] zero
    input  logic                   s_axis_tlast,  // end_of_string
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] frame_slot, [3] evicted_valid,
                                                  // [23:4] evicted_page,
                                                  // [55:24] fault_total, [87:56] hit_total
    output logic                   m_axis_tuser,  // hit
    output logic                   m_axis_tlast   // is_final
);

    logic [CFG_W-1:0] r_cfg;
    logic             r_out_vld;
    t_result          r_out;

    logic             res_valid;
    logic             res_ready;
    t_result          res;

    // Hold the frame count; the user must change it only between strings, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    fpr_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_page      (PAGE_BITS'(s_axis_tdata[PAGE_W-1:0])),
        .i_final     (s_axis_tlast),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register: load when empty or when the current beat is taken.
    assign res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.hit;
    assign m_axis_tlast  = r_out.final_ref;
    assign m_axis_tdata  = {r_out.hits, r_out.faults, r_out.ev_page,
                            r_out.ev_valid, r_out.slot};

    `ASSERT_CLK(a_out_hold, (r_out_vld && !m_axis_tready) |=> r_out_vld,
                "result dropped while stalled")

endmodule
